// File: hw/rtl/cplx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cplx_pkg: shared types and constants for the charlieplexed LED scan driver
// Command and result transaction types, command codes, register indexes and
// the fixed anode and cathode line of each LED.
// ----------------------------------------------------------------------------
package cplx_pkg;

  // LED count and field widths.
  localparam int LED_COUNT   = 9;
  localparam int LED_ID_W    = 4;
  localparam int LINE_W      = 2;
  localparam int DUTY_W      = 8;
  localparam int PERIOD_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Reset value of every LED duty.
  localparam logic [DUTY_W-1:0] DEFAULT_DUTY = 8'd255;

  // Highest LED index, where the scan wraps.
  localparam logic [LED_ID_W-1:0] LAST_LED = LED_ID_W'(LED_COUNT - 1);

  // Command codes.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_DUTY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_PERIOD  = 2'd1;

  // Configuration reset values.
  localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET = 16'd500;
  localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET  = 16'd2;

  // Fixed lines of each LED in the charlieplex matrix.
  localparam logic [LINE_W-1:0] ANODE_OF [LED_COUNT] =
    '{2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd3, 2'd0};
  localparam logic [LINE_W-1:0] CATHODE_OF [LED_COUNT] =
    '{2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd1, 2'd3, 2'd2, 2'd3};

  // One command transaction.
  typedef struct packed {
    logic [1:0]          command;
    logic [LED_ID_W-1:0] led_id;
    logic                turn_on;
    logic [DUTY_W-1:0]   duty;
    logic                blink_enable;
  } cmd_t;

  // One scan result transaction.
  typedef struct packed {
    logic [LED_ID_W-1:0] scan_led;
    logic                lit;
    logic [LINE_W-1:0]   anode_line;
    logic [LINE_W-1:0]   cathode_line;
    logic [DUTY_W-1:0]   pwm_duty;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/charlieplex_led_scan_blink.sv
`default_nettype none
// Flow: an accepted command waits in the input register until the result register is
// free; the core then processes it and loads any scan result into the result register.
// Throughput: one command per cycle while the result register is free; a stalled
// result holds the command behind it in the input register.
// Reset: synchronous, active high; empties both registers, clears LED flags, counters
// and scan index, sets default duties and blink phases on, restores period registers.
// ----------------------------------------------------------------------------
// charlieplex_led_scan_blink: charlieplexed LED scan driver with blinking
// Takes tick and LED setting commands and emits one scan result per scan
// period with the LED's fixed line pair, duty and lit state.
// ----------------------------------------------------------------------------
module charlieplex_led_scan_blink (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  cplx_pkg::cmd_t                        cmd,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output cplx_pkg::result_t                     res,
  input  wire logic                             cfg_we,
  input  wire logic [cplx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cplx_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cplx_pkg::*;

  logic    item_valid;
  cmd_t    item;
  logic    take;
  logic    free;
  logic    result_valid;
  result_t result;

  // The held command is processed whenever the result slot can take a result.
  assign take = item_valid && free;

  // Command input register.
  cplx_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // State and scan logic.
  cplx_core u_core (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  // Result register.
  cplx_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (result_valid),
    .load_data (result),
    .free      (free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
`default_nettype wire

// File: hw/rtl/cplx_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cplx_in_reg: command input register
// Holds one accepted command until the core takes it; accepts a new command
// in the same cycle the held one is taken.
// ----------------------------------------------------------------------------
module cplx_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  cplx_pkg::cmd_t      cmd,
  output logic                item_valid,
  output cplx_pkg::cmd_t      item,
  input  wire logic           take
);
  import cplx_pkg::*;

  // Room exists when empty or when the held command leaves this cycle.
  assign cmd_ready = !item_valid || take;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd_ready) begin
      item_valid <= cmd_valid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      item <= cmd;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cplx_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cplx_core: LED state, blink and scan timing
// Keeps the per-LED settings, the blink phases, the elapsed counters and the
// scan index, and forms the scan result for a tick that reaches the period.
// ----------------------------------------------------------------------------
module cplx_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           take,
  input  cplx_pkg::cmd_t                      item,
  input  wire logic                           cfg_we,
  input  wire logic [cplx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cplx_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                result_valid,
  output cplx_pkg::result_t                   result
);
  import cplx_pkg::*;

  logic [PERIOD_W-1:0] blink_period;
  logic [PERIOD_W-1:0] scan_period;
  logic [PERIOD_W-1:0] blink_elapsed;
  logic [PERIOD_W-1:0] scan_elapsed;
  logic [LED_ID_W-1:0] scan_index;
  logic                led_on         [LED_COUNT];
  logic [DUTY_W-1:0]   led_duty       [LED_COUNT];
  logic                led_blinks     [LED_COUNT];
  logic                blink_phase_on [LED_COUNT];

  logic                blink_phase_next [LED_COUNT];
  logic [PERIOD_W-1:0] blink_bump;
  logic [PERIOD_W-1:0] scan_bump;
  logic                blink_fire;
  logic                scan_fire;
  logic                is_tick;
  logic                is_set;
  logic                is_duty;
  logic                id_ok;
  logic [LED_ID_W-1:0] scan_index_next;

  // Command decode.
  assign is_tick = take && (item.command == CMD_TICK);
  assign is_set  = take && (item.command == CMD_SET);
  assign is_duty = take && (item.command == CMD_DUTY);
  assign id_ok   = item.led_id <= LAST_LED;

  // Saturating elapsed counters and period compares.
  assign blink_bump = (blink_elapsed == '1) ? blink_elapsed : blink_elapsed + 1'b1;
  assign scan_bump  = (scan_elapsed == '1) ? scan_elapsed : scan_elapsed + 1'b1;
  assign blink_fire = blink_bump >= blink_period;
  assign scan_fire  = scan_bump >= scan_period;

  // Blink phases after this tick; the scan sees the updated phase.
  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      blink_phase_next[i] = blink_phase_on[i] ^ (blink_fire && led_blinks[i]);
    end
  end

  assign scan_index_next = (scan_index == LAST_LED) ? '0 : scan_index + 1'b1;

  // Scan result for the current LED.
  assign result_valid        = is_tick && scan_fire;
  assign result.scan_led     = scan_index;
  assign result.lit          = led_on[scan_index] &&
                               !(led_blinks[scan_index] && !blink_phase_next[scan_index]);
  assign result.anode_line   = ANODE_OF[scan_index];
  assign result.cathode_line = CATHODE_OF[scan_index];
  assign result.pwm_duty     = led_duty[scan_index];

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period <= BLINK_PERIOD_RESET;
      scan_period  <= SCAN_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLINK_PERIOD: blink_period <= cfg_data[PERIOD_W-1:0];
        REG_SCAN_PERIOD:  scan_period  <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Elapsed counters advance on ticks; the scan index on ticks that reach the scan period.
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_elapsed <= '0;
      scan_elapsed  <= '0;
      scan_index    <= '0;
    end else if (is_tick) begin
      blink_elapsed <= blink_fire ? '0 : blink_bump;
      scan_elapsed  <= scan_fire ? '0 : scan_bump;
      if (scan_fire) begin
        scan_index <= scan_index_next;
      end
    end
  end

  // Per-LED settings and blink phases.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        led_on[i]         <= 1'b0;
        led_duty[i]       <= DEFAULT_DUTY;
        led_blinks[i]     <= 1'b0;
        blink_phase_on[i] <= 1'b1;
      end
    end else begin
      if (is_tick) begin
        for (int i = 0; i < LED_COUNT; i++) begin
          blink_phase_on[i] <= blink_phase_next[i];
        end
      end
      if (is_set && id_ok) begin
        led_on[item.led_id]     <= item.turn_on;
        led_duty[item.led_id]   <= item.duty;
        led_blinks[item.led_id] <= item.blink_enable;
      end
      if (is_duty && id_ok) begin
        led_duty[item.led_id] <= item.duty;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cplx_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cplx_out_reg: result register
// Holds one scan result until the consumer takes it and reports when a new
// result may be loaded.
// ----------------------------------------------------------------------------
module cplx_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  cplx_pkg::result_t  load_data,
  output logic               free,
  output logic               res_valid,
  input  wire logic          res_ready,
  output cplx_pkg::result_t  res
);
  import cplx_pkg::*;

  // The slot is free when empty or emptied in this cycle.
  assign free = !res_valid || res_ready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cplx_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cplx_checker: port-level checks for the LED scan driver
// Watches the top-level ports for reset behavior, stall hold, scan order and
// valid line pairs.
// ----------------------------------------------------------------------------
module cplx_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_ready,
  input  wire logic                             res_valid,
  input  wire logic                             res_ready,
  input  cplx_pkg::result_t                     res
);
  import cplx_pkg::*;

  logic [LED_ID_W-1:0] expected_led;

  // Next LED the scan should report, stepped on each delivered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_led <= '0;
    end else if (res_valid && res_ready) begin
      expected_led <= (expected_led == LAST_LED) ? '0 : expected_led + 1'b1;
    end
  end

  // After reset the block is empty and ready for a command.
  assert property (@(posedge clk) rst |=> cmd_ready && !res_valid)
    else $error("block not empty after reset");

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // Scan results visit the LEDs in order, wrapping after the last.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.scan_led == expected_led)
    else $error("scan order broken");

  // A driven pair always uses two different lines.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.anode_line != res.cathode_line)
    else $error("anode and cathode on the same line");

endmodule

bind charlieplex_led_scan_blink cplx_checker u_checker (.*);
`default_nettype wire
